### sv/fat12_pkg.sv
// Shared types and constants for the FAT12 next-sector lookup block.
// No dependencies; every other file in sv/ imports this package.
`default_nettype none
package fat12_pkg;

   // Table store geometry
   localparam int TABLE_BYTES = 8192;
   localparam int TABLE_AW    = $clog2(TABLE_BYTES);

   // CSR port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic [2:0] REG_BYTES_PER_SECTOR    = 3'd0;
   localparam logic [2:0] REG_SECTORS_PER_CLUSTER = 3'd1;
   localparam logic [2:0] REG_RESERVED_SECTORS    = 3'd2;
   localparam logic [2:0] REG_TABLE_COPIES        = 3'd3;
   localparam logic [2:0] REG_TABLE_SECTORS       = 3'd4;
   localparam logic [2:0] REG_ROOT_ENTRIES        = 3'd5;

   // Request kinds
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   // Result status codes
   localparam logic [2:0] ST_NEXT      = 3'd0;
   localparam logic [2:0] ST_END       = 3'd1;
   localparam logic [2:0] ST_BADENTRY  = 3'd2;
   localparam logic [2:0] ST_BADSECTOR = 3'd3;
   localparam logic [2:0] ST_WRITTEN   = 3'd4;

   // Table entry classes
   localparam logic [11:0] ENTRY_MIN      = 12'h002;
   localparam logic [11:0] ENTRY_MAX      = 12'hFEF;
   localparam logic [11:0] ENTRY_EOC      = 12'hFF8;
   localparam logic [11:0] ENTRY_MASK     = 12'hFFF;
   localparam int          DIR_ENTRY_BYTES = 32;

   // Shared divider: dividend width covers root_entries*32 + sector size
   localparam int DIV_W  = 22;
   localparam int DIV_DW = 13;
   localparam int DIV_CW = $clog2(DIV_W + 1);
   localparam int SPC_STEPS = 16;

   typedef struct packed {
      logic        kind;
      logic [12:0] byte_address;
      logic [7:0]  byte_value;
      logic [15:0] sector;
   } req_type;

   typedef struct packed {
      logic [15:0] next_sector;
      logic [11:0] table_entry;
      logic [2:0]  status;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DIV_DW-1:0] divisor;
      logic [DIV_CW-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

### sv/fat12_divider.sv
// Iterative restoring divider, one quotient bit per cycle, shared by the
// root-directory size and the sector-to-cluster divisions. Uses fat12_pkg.
`default_nettype none
module fat12_divider (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fat12_pkg::div_req_type div_req,
   output fat12_pkg::div_rsp_type      div_rsp
);
   import fat12_pkg::*;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] div_ff, div_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;

   logic [DIV_DW:0] trial;
   logic            fits;

   // dividend bits leave at the top of quo_ff, quotient bits enter at the bottom
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = div_req.steps;
         rem_in = '0;
         div_in = div_req.divisor;
         quo_in = div_req.dividend;
      end else if (run_ff) begin
         rem_in = fits ? DIV_DW'(trial - {1'b0, div_ff}) : trial[DIV_DW-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CW'(1);
         if (cnt_ff == DIV_CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

### sv/fat12_table_store.sv
// Byte store holding one allocation table copy: one write port, one
// registered read port. Uses fat12_pkg for the store size.
`default_nettype none
module fat12_table_store (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [fat12_pkg::TABLE_AW-1:0] wr_addr,
   input  wire logic [7:0]                     wr_data,
   input  wire logic [fat12_pkg::TABLE_AW-1:0] rd_addr,
   output logic [7:0]                          rd_data
);
   import fat12_pkg::*;

   logic [7:0] mem [TABLE_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### sv/fat12_next_sector_lookup.sv
// FAT12 next-sector lookup: top level with CSRs, sequencer and table store.
// Depends on fat12_pkg, fat12_divider and fat12_table_store.
//
// Usage:
//  - Boot-sector geometry is written through the csr_ APB port (registers at
//    byte addresses 0,4,..,20); pready is always high, writes only while idle.
//  - An item is taken when start is high and busy is low. A write item
//    (kind 0) stores one table byte and answers status 4 in the next cycle;
//    busy stays low, so write items can stream one per cycle.
//  - A lookup item (kind 1) raises busy until its single result is shown.
//    The first lookup after reset or after any CSR write recomputes the
//    root directory size; later lookups use the cached data-region start.
//    The shared one-bit-per-cycle divider runs 16 steps per cluster
//    division and 22 per root size division.
//  - Each result appears on rsp_item for one cycle with rsp_strobe high; the
//    receiver cannot stall, so nothing is held back.
//  - Reset (synchronous) restores the default geometry and drops the cached
//    start. Table bytes are undefined until written; look up only chains
//    whose entries were loaded.
`default_nettype none
module fat12_next_sector_lookup (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         start,
   output logic                              busy,
   input  wire fat12_pkg::req_type           req_item,
   // result channel
   output logic                              rsp_strobe,
   output fat12_pkg::rsp_type                rsp_item,
   // configuration port
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [fat12_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [fat12_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [fat12_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                              csr_pready
);
   import fat12_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ROOT_WAIT,
      S_CHECK,
      S_CLU_WAIT,
      S_OFFSET,
      S_READ_LO,
      S_READ_HI,
      S_ENTRY,
      S_CLASSIFY,
      S_SCALE
   } state_type;

   // ---------------- CSRs ----------------
   logic [12:0] bps_ff;
   logic [7:0]  spc_ff;
   logic [15:0] rsvd_ff;
   logic [2:0]  copies_ff;
   logic [15:0] tsec_ff;
   logic [15:0] root_ff;
   logic        cfg_wr;
   logic [2:0]  cfg_idx;

   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite;
   assign cfg_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff    <= 13'd512;
         spc_ff    <= 8'd1;
         rsvd_ff   <= 16'd1;
         copies_ff <= 3'd2;
         tsec_ff   <= 16'd9;
         root_ff   <= 16'd224;
      end else if (cfg_wr) begin
         case (cfg_idx)
            REG_BYTES_PER_SECTOR:    bps_ff    <= csr_pwdata[12:0];
            REG_SECTORS_PER_CLUSTER: spc_ff    <= csr_pwdata[7:0];
            REG_RESERVED_SECTORS:    rsvd_ff   <= csr_pwdata[15:0];
            REG_TABLE_COPIES:        copies_ff <= csr_pwdata[2:0];
            REG_TABLE_SECTORS:       tsec_ff   <= csr_pwdata[15:0];
            REG_ROOT_ENTRIES:        root_ff   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_BYTES_PER_SECTOR:    csr_prdata = CSR_DW'(bps_ff);
         REG_SECTORS_PER_CLUSTER: csr_prdata = CSR_DW'(spc_ff);
         REG_RESERVED_SECTORS:    csr_prdata = CSR_DW'(rsvd_ff);
         REG_TABLE_COPIES:        csr_prdata = CSR_DW'(copies_ff);
         REG_TABLE_SECTORS:       csr_prdata = CSR_DW'(tsec_ff);
         REG_ROOT_ENTRIES:        csr_prdata = CSR_DW'(root_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // zero sizes count as one
   logic [12:0] bps_eff;
   logic [7:0]  spc_eff;
   assign bps_eff = (bps_ff == '0) ? 13'd1 : bps_ff;
   assign spc_eff = (spc_ff == '0) ? 8'd1 : spc_ff;

   // ---------------- shared divider and table store ----------------
   div_req_type div_req_ff, div_req_in;
   div_rsp_type div_rsp;

   fat12_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   logic                take;
   logic                st_wr_en;
   logic [TABLE_AW-1:0] rd_addr_ff, rd_addr_in;
   logic [7:0]          rd_data;

   assign take     = start & ~busy;
   assign st_wr_en = take & (req_item.kind == KIND_WRITE)
                     & (17'(req_item.byte_address) < 17'(TABLE_BYTES));

   fat12_table_store u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (TABLE_AW'(req_item.byte_address)),
      .wr_data (req_item.byte_value),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   // ---------------- sequencer ----------------
   state_type   state_ff, state_in;
   logic        start_ok_ff, start_ok_in;
   logic [15:0] sector_ff, sector_in;
   logic [18:0] fat_secs_ff, fat_secs_in;
   logic [22:0] dstart_ff, dstart_in;
   logic [16:0] cluster_ff, cluster_in;
   logic [7:0]  lo_ff, lo_in;
   logic [11:0] entry_ff, entry_in;
   logic [19:0] product_ff, product_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   rsp_type     rsp_ff, rsp_in;

   logic [17:0] off;
   logic [15:0] diff;
   logic [23:0] nsec;
   logic [11:0] entry_rd;

   assign off  = 18'(cluster_ff) + 18'(cluster_ff >> 1);
   assign diff = sector_ff - dstart_ff[15:0];
   assign nsec = 24'(dstart_ff) + 24'(product_ff);
   // odd clusters take the upper 12 bits of the little-endian pair
   assign entry_rd = cluster_ff[0] ? {rd_data, lo_ff[7:4]}
                                   : ({rd_data[3:0], lo_ff} & ENTRY_MASK);

   always_comb begin
      state_in      = state_ff;
      start_ok_in   = start_ok_ff;
      sector_in     = sector_ff;
      fat_secs_in   = fat_secs_ff;
      dstart_in     = dstart_ff;
      cluster_in    = cluster_ff;
      rd_addr_in    = rd_addr_ff;
      lo_in         = lo_ff;
      entry_in      = entry_ff;
      product_in    = product_ff;
      div_req_in    = div_req_ff;
      div_req_in.start = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      if (cfg_wr) begin
         start_ok_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (req_item.kind == KIND_WRITE) begin
                  rsp_in        = '{next_sector: '0, table_entry: '0, status: ST_WRITTEN};
                  rsp_strobe_in = 1'b1;
               end else begin
                  sector_in   = req_item.sector;
                  fat_secs_in = 19'(copies_ff) * 19'(tsec_ff);
                  if (start_ok_ff) begin
                     state_in = S_CHECK;
                  end else begin
                     // ceil(root_entries*32 / bytes_per_sector)
                     div_req_in.start    = 1'b1;
                     div_req_in.dividend = DIV_W'(root_ff) * DIV_W'(DIR_ENTRY_BYTES)
                                           + DIV_W'(bps_eff) - DIV_W'(1);
                     div_req_in.divisor  = DIV_DW'(bps_eff);
                     div_req_in.steps    = DIV_CW'(DIV_W);
                     state_in            = S_ROOT_WAIT;
                  end
               end
            end
         end
         S_ROOT_WAIT: begin
            if (div_rsp.done) begin
               dstart_in   = 23'(rsvd_ff) + 23'(fat_secs_ff) + 23'(div_rsp.quotient);
               start_ok_in = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (23'(sector_ff) < dstart_ff) begin
               rsp_in        = '{next_sector: '0, table_entry: '0, status: ST_BADSECTOR};
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               // 16-bit dividend sits at the top so only 16 steps are run
               div_req_in.start    = 1'b1;
               div_req_in.dividend = {diff, (DIV_W - SPC_STEPS)'(0)};
               div_req_in.divisor  = DIV_DW'(spc_eff);
               div_req_in.steps    = DIV_CW'(SPC_STEPS);
               state_in            = S_CLU_WAIT;
            end
         end
         S_CLU_WAIT: begin
            if (div_rsp.done) begin
               cluster_in = 17'(div_rsp.quotient[SPC_STEPS-1:0]) + 17'(ENTRY_MIN);
               state_in   = S_OFFSET;
            end
         end
         S_OFFSET: begin
            if (off + 18'd1 >= 18'(TABLE_BYTES)) begin
               rsp_in        = '{next_sector: '0, table_entry: '0, status: ST_BADSECTOR};
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               rd_addr_in = TABLE_AW'(off);
               state_in   = S_READ_LO;
            end
         end
         S_READ_LO: begin
            rd_addr_in = rd_addr_ff + TABLE_AW'(1);
            state_in   = S_READ_HI;
         end
         S_READ_HI: begin
            lo_in    = rd_data;
            state_in = S_ENTRY;
         end
         S_ENTRY: begin
            entry_in = entry_rd;
            state_in = S_CLASSIFY;
         end
         S_CLASSIFY: begin
            if (entry_ff >= ENTRY_EOC) begin
               rsp_in        = '{next_sector: '0, table_entry: entry_ff, status: ST_END};
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else if (entry_ff >= ENTRY_MIN && entry_ff <= ENTRY_MAX) begin
               product_in = 20'(entry_ff - ENTRY_MIN) * 20'(spc_eff);
               state_in   = S_SCALE;
            end else begin
               rsp_in        = '{next_sector: '0, table_entry: entry_ff, status: ST_BADENTRY};
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SCALE: begin
            if (nsec > 24'h00FFFF) begin
               rsp_in = '{next_sector: '0, table_entry: entry_ff, status: ST_BADENTRY};
            end else begin
               rsp_in = '{next_sector: nsec[15:0], table_entry: entry_ff, status: ST_NEXT};
            end
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         start_ok_ff      <= 1'b0;
         rsp_strobe_ff    <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         state_ff         <= state_in;
         start_ok_ff      <= start_ok_in;
         rsp_strobe_ff    <= rsp_strobe_in;
         div_req_ff.start <= div_req_in.start;
      end
      div_req_ff.dividend <= div_req_in.dividend;
      div_req_ff.divisor  <= div_req_in.divisor;
      div_req_ff.steps    <= div_req_in.steps;
      sector_ff   <= sector_in;
      fat_secs_ff <= fat_secs_in;
      dstart_ff   <= dstart_in;
      cluster_ff  <= cluster_in;
      rd_addr_ff  <= rd_addr_in;
      lo_ff       <= lo_in;
      entry_ff    <= entry_in;
      product_ff  <= product_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
`default_nettype wire

### tb/tb_fat12_next_sector_lookup.sv
// Self-checking testbench for fat12_next_sector_lookup: table loads, chain lookups, CSR geometry.
// Depends on fat12_pkg and the RTL under sv/; the predictor below tracks its own table and CSRs.
module tb_fat12_next_sector_lookup;
   import fat12_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 64;
   // highest cluster whose byte pair still fits in the store
   localparam int LAST_CLUSTER = (2 * TABLE_BYTES - 3) / 3;

   typedef struct {
      bit      known;
      rsp_type value;
   } fixed_answer_type;

   typedef struct {
      req_type          item;
      fixed_answer_type check;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_type             req_item = '0;
   logic                rsp_strobe;
   rsp_type             rsp_item;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // geometry as programmed
   logic [12:0] cfg_bps = 13'd512;
   logic [7:0]  cfg_spc = 8'd1;
   logic [15:0] cfg_rsv = 16'd1;
   logic [2:0]  cfg_copies = 3'd2;
   logic [15:0] cfg_ts = 16'd9;
   logic [15:0] cfg_root = 16'd224;

   logic [7:0]  fat_bytes [TABLE_BYTES];    // predictor copy, updated on accepted beats
   logic [7:0]  plan_bytes [TABLE_BYTES];   // stimulus copy, updated when a write is issued
   bit          plan_loaded [TABLE_BYTES];

   rsp_type          expected_answers [$];
   fixed_answer_type typed_answers [$];
   stim_row_type     directed_rows [$];
   int unsigned      linked_clusters [$];

   int  fail_count = 0;
   int  cycle_count = 0;
   int  items_sent = 0;
   int  settings_used = 1;
   int  status_tally [5] = '{default: 0};
   bit  allow_gaps = 1'b1;

   fat12_next_sector_lookup uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned cluster_span();
      return (cfg_spc == '0) ? 1 : cfg_spc;
   endfunction

   function automatic int unsigned region_start();
      int unsigned bps;
      int unsigned root_secs;
      int unsigned tables;
      bps = (cfg_bps == '0) ? 1 : cfg_bps;
      root_secs = (cfg_root * 32'd32 + bps - 1) / bps;
      tables = cfg_copies * cfg_ts;
      return cfg_rsv + tables + root_secs;
   endfunction

   function automatic rsp_type answer(input int unsigned nsec, input int unsigned ncl,
                                      input logic [2:0] st);
      rsp_type a;
      a.next_sector = nsec[15:0];
      a.table_entry = ncl[11:0];
      a.status = st;
      return a;
   endfunction

   function automatic rsp_type predict_link(input req_type r);
      int unsigned spc, first, cl, off, ent, nsec;
      logic [15:0] pair;
      if (r.kind == KIND_WRITE) begin
         if (r.byte_address < TABLE_BYTES) fat_bytes[r.byte_address] = r.byte_value;
         return answer(0, 0, ST_WRITTEN);
      end
      spc = cluster_span();
      first = region_start();
      if (r.sector < first) return answer(0, 0, ST_BADSECTOR);
      cl = (r.sector - first) / spc + 2;
      off = cl + (cl >> 1);
      if (off + 1 >= TABLE_BYTES) return answer(0, 0, ST_BADSECTOR);
      pair = {fat_bytes[off + 1], fat_bytes[off]};
      ent = cl[0] ? (pair >> 4) : (pair & ENTRY_MASK);
      if (ent >= ENTRY_EOC) return answer(0, ent, ST_END);
      if (ent >= ENTRY_MIN && ent <= ENTRY_MAX) begin
         nsec = first + (ent - 2) * spc;
         if (nsec > 32'hFFFF) return answer(0, ent, ST_BADENTRY);
         return answer(nsec, ent, ST_NEXT);
      end
      return answer(0, ent, ST_BADENTRY);
   endfunction

   // result check and prediction, both on the same edge
   always @(posedge clock) begin
      rsp_type          want;
      fixed_answer_type note;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_answers.size() == 0) begin
               $error("result beat with nothing outstanding (status %0d)", rsp_item.status);
               fail_count++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_item.next_sector !== want.next_sector) begin
                  $error("next_sector: expected %0d, got %0d",
                         want.next_sector, rsp_item.next_sector);
                  fail_count++;
               end
               if (rsp_item.table_entry !== want.table_entry) begin
                  $error("table_entry: expected 0x%03h, got 0x%03h",
                         want.table_entry, rsp_item.table_entry);
                  fail_count++;
               end
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_item.status);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            note = typed_answers.pop_front();
            want = predict_link(req_item);
            if (note.known) want = note.value;
            expected_answers.push_back(want);
            if (want.status <= ST_WRITTEN) status_tally[want.status]++;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   task automatic csr_write(input logic [2:0] idx, input logic [CSR_DW-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'({idx, 2'b00});
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [2:0] idx, input logic [CSR_DW-1:0] want);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= CSR_AW'({idx, 2'b00});
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      if (csr_prdata !== want) begin
         $error("csr[%0d]: expected 0x%08h, got 0x%08h", idx, want, csr_prdata);
         fail_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_geometry();
      csr_read(REG_BYTES_PER_SECTOR, CSR_DW'(cfg_bps));
      csr_read(REG_SECTORS_PER_CLUSTER, CSR_DW'(cfg_spc));
      csr_read(REG_RESERVED_SECTORS, CSR_DW'(cfg_rsv));
      csr_read(REG_TABLE_COPIES, CSR_DW'(cfg_copies));
      csr_read(REG_TABLE_SECTORS, CSR_DW'(cfg_ts));
      csr_read(REG_ROOT_ENTRIES, CSR_DW'(cfg_root));
   endtask

   task automatic set_geometry(input logic [12:0] bps, input logic [7:0] spc,
                               input logic [15:0] rsv, input logic [2:0] copies,
                               input logic [15:0] ts, input logic [15:0] root);
      csr_write(REG_BYTES_PER_SECTOR, CSR_DW'(bps));
      csr_write(REG_SECTORS_PER_CLUSTER, CSR_DW'(spc));
      csr_write(REG_RESERVED_SECTORS, CSR_DW'(rsv));
      csr_write(REG_TABLE_COPIES, CSR_DW'(copies));
      csr_write(REG_TABLE_SECTORS, CSR_DW'(ts));
      csr_write(REG_ROOT_ENTRIES, CSR_DW'(root));
      cfg_bps = bps;
      cfg_spc = spc;
      cfg_rsv = rsv;
      cfg_copies = copies;
      cfg_ts = ts;
      cfg_root = root;
      settings_used++;
      check_geometry();
   endtask

   function automatic req_type make_write(input logic [12:0] addr, input logic [7:0] val);
      req_type r;
      r.kind = KIND_WRITE;
      r.byte_address = addr;
      r.byte_value = val;
      r.sector = 16'($urandom);
      return r;
   endfunction

   function automatic req_type make_lookup(input logic [15:0] sec);
      req_type r;
      r.kind = KIND_LOOKUP;
      r.byte_address = 13'($urandom);
      r.byte_value = 8'($urandom);
      r.sector = sec;
      return r;
   endfunction

   function automatic logic [11:0] pick_entry();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 12'($urandom_range(2, 200));
      if (roll < 60) return 12'($urandom_range(2, ENTRY_MAX));
      if (roll < 80) return 12'($urandom_range(ENTRY_EOC, ENTRY_MASK));
      roll = $urandom_range(0, 9);
      if (roll < 2) return 12'(roll);
      return 12'hFF0 + 12'(roll - 2);
   endfunction

   // any sector inside cluster c; caller keeps c at or below the last reachable one
   function automatic logic [15:0] sector_of_cluster(input int unsigned c);
      int unsigned spc, s;
      spc = cluster_span();
      s = region_start() + (c - 2) * spc + $urandom_range(0, spc - 1);
      return (s > 32'hFFFF) ? 16'hFFFF : s[15:0];
   endfunction

   task automatic pace();
      int gap;
      if (allow_gaps && $urandom_range(0, 99) < 37) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_item(input req_type item, input bit known, input rsp_type value);
      fixed_answer_type note;
      note.known = known;
      note.value = value;
      typed_answers.push_back(note);
      start <= 1'b1;
      req_item <= item;
      if (item.kind == KIND_WRITE) begin
         plan_bytes[item.byte_address] = item.byte_value;
         plan_loaded[item.byte_address] = 1'b1;
      end
      do begin
         @(posedge clock);
      end while (busy);
      items_sent++;
      pace();
   endtask

   task automatic drain(input int settle);
      start <= 1'b0;
      @(posedge clock);
      while (expected_answers.size() != 0 || busy) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic add_row(input req_type item, input bit known, input rsp_type value);
      stim_row_type row;
      row.item = item;
      row.check.known = known;
      row.check.value = value;
      directed_rows.push_back(row);
   endtask

   // random mix: mostly entry loads followed by a lookup through them
   task automatic run_mix(input int count);
      int unsigned spc, ds, cmax, c, off, lo, hi, pick, stop;
      logic [11:0] e;
      logic [7:0]  b0, b1;
      stop = items_sent + count;
      spc = cluster_span();
      ds = region_start();
      cmax = (ds <= 32'hFFFF) ? (32'hFFFF - ds) / spc + 2 : 0;
      if (cmax > LAST_CLUSTER) cmax = LAST_CLUSTER;
      lo = ds + (LAST_CLUSTER - 1) * spc;
      while (items_sent < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 55 && cmax >= 2) begin
            c = $urandom_range(2, cmax);
            if (cmax == LAST_CLUSTER && $urandom_range(0, 7) == 0)
               c = $urandom_range(LAST_CLUSTER - 3, LAST_CLUSTER);
            e = pick_entry();
            off = c + (c >> 1);
            // keep the neighbor's nibble in the shared byte
            if (c[0]) begin
               b0 = {e[3:0], plan_loaded[off] ? plan_bytes[off][3:0] : 4'($urandom)};
               b1 = e[11:4];
            end else begin
               b0 = e[7:0];
               b1 = {plan_loaded[off + 1] ? plan_bytes[off + 1][7:4] : 4'($urandom), e[11:8]};
            end
            send_item(make_write(13'(off), b0), 1'b0, '0);
            send_item(make_write(13'(off + 1), b1), 1'b0, '0);
            linked_clusters.push_back(c);
            send_item(make_lookup(sector_of_cluster(c)), 1'b0, '0);
         end else if (pick < 70 && linked_clusters.size() > 0 &&
                      linked_clusters[0] <= cmax) begin
            c = linked_clusters[$urandom_range(0, linked_clusters.size() - 1)];
            if (c > cmax) c = linked_clusters[0];
            send_item(make_lookup(sector_of_cluster(c)), 1'b0, '0);
         end else if (pick < 82 && (ds > 0 || lo <= 32'hFFFF)) begin
            if (ds > 0 && (lo > 32'hFFFF || $urandom_range(0, 1) == 0)) begin
               hi = (ds > 32'h10000) ? 32'hFFFF : ds - 1;
               send_item(make_lookup(16'($urandom_range(0, hi))), 1'b0, '0);
            end else begin
               send_item(make_lookup(16'($urandom_range(lo, 32'hFFFF))), 1'b0, '0);
            end
         end else begin
            case ($urandom_range(0, 9))
               0: send_item(make_write(13'd0, 8'($urandom)), 1'b0, '0);
               1: send_item(make_write(13'(TABLE_BYTES - 1), 8'($urandom)), 1'b0, '0);
               default: send_item(make_write(13'($urandom), 8'($urandom)), 1'b0, '0);
            endcase
         end
      end
   endtask

   initial begin
      logic [12:0] bps;
      logic [7:0]  spc;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_geometry();

      // default geometry: data region starts at sector 33, cluster 2
      add_row(make_lookup(16'd0), 1'b1, answer(0, 0, ST_BADSECTOR));
      add_row(make_lookup(16'd32), 1'b1, answer(0, 0, ST_BADSECTOR));
      add_row(make_lookup(16'hFFFF), 1'b1, answer(0, 0, ST_BADSECTOR));
      add_row(make_write(13'd0, 8'hF0), 1'b1, answer(0, 0, ST_WRITTEN));
      add_row(make_write(13'h1FFF, 8'hFF), 1'b1, answer(0, 0, ST_WRITTEN));
      // clusters 2,3 -> entries 0x003, 0x004
      add_row(make_write(13'd3, 8'h03), 1'b1, answer(0, 0, ST_WRITTEN));
      add_row(make_write(13'd4, 8'h40), 1'b1, answer(0, 0, ST_WRITTEN));
      add_row(make_write(13'd5, 8'h00), 1'b1, answer(0, 0, ST_WRITTEN));
      add_row(make_lookup(16'd33), 1'b0, '0);
      add_row(make_lookup(16'd34), 1'b0, '0);
      // clusters 4,5 -> first end-of-chain code, last reserved code
      add_row(make_write(13'd6, 8'hF8), 1'b1, answer(0, 0, ST_WRITTEN));
      add_row(make_write(13'd7, 8'h7F), 1'b1, answer(0, 0, ST_WRITTEN));
      add_row(make_write(13'd8, 8'hFF), 1'b1, answer(0, 0, ST_WRITTEN));
      add_row(make_lookup(16'd35), 1'b1, answer(0, 12'hFF8, ST_END));
      add_row(make_lookup(16'd36), 1'b1, answer(0, 12'hFF7, ST_BADENTRY));
      // clusters 6,7 -> free entry, highest valid entry
      add_row(make_write(13'd9, 8'h00), 1'b1, answer(0, 0, ST_WRITTEN));
      add_row(make_write(13'd10, 8'hF0), 1'b1, answer(0, 0, ST_WRITTEN));
      add_row(make_write(13'd11, 8'hFE), 1'b1, answer(0, 0, ST_WRITTEN));
      add_row(make_lookup(16'd37), 1'b1, answer(0, 0, ST_BADENTRY));
      add_row(make_lookup(16'd38), 1'b0, '0);
      // clusters 8,9 -> last end-of-chain code, reserved entry 0x001
      add_row(make_write(13'd12, 8'hFF), 1'b1, answer(0, 0, ST_WRITTEN));
      add_row(make_write(13'd13, 8'h1F), 1'b1, answer(0, 0, ST_WRITTEN));
      add_row(make_write(13'd14, 8'h00), 1'b1, answer(0, 0, ST_WRITTEN));
      add_row(make_lookup(16'd39), 1'b1, answer(0, 12'hFFF, ST_END));
      add_row(make_lookup(16'd40), 1'b1, answer(0, 12'h001, ST_BADENTRY));
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].check.known,
                   directed_rows[i].check.value);

      run_mix(250);
      drain(8);
      // zero sizes fall back to one; data region starts at sector 0
      set_geometry(13'd0, 8'd0, 16'd0, 3'd0, 16'd0, 16'd0);
      run_mix(250);
      drain(8);
      set_geometry(13'h1FFF, 8'hFF, 16'hFFFF, 3'd7, 16'hFFFF, 16'hFFFF);
      run_mix(40);
      drain(8);
      // big clusters push the next sector of any entry above 258 past 16 bits; no gaps here
      allow_gaps = 1'b0;
      set_geometry(13'd4096, 8'd255, 16'd0, 3'd1, 16'd1, 16'd16);
      run_mix(250);
      drain(8);
      allow_gaps = 1'b1;
      for (int round = 0; round < 5; round++) begin
         bps = ($urandom_range(0, 4) == 0) ? 13'($urandom) : 13'(1 << $urandom_range(0, 12));
         spc = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'(1 << $urandom_range(0, 7));
         set_geometry(bps, spc, 16'($urandom_range(0, 40)), 3'($urandom_range(0, 7)),
                      16'($urandom_range(0, 48)), 16'($urandom_range(0, 1024)));
         run_mix(250);
         drain(8);
      end

      drain(TAIL_CYCLES);
      $display("Ran %0d beats over %0d geometry settings: %0d table writes, %0d lookups",
               items_sent, settings_used, status_tally[ST_WRITTEN],
               items_sent - status_tally[ST_WRITTEN]);
      $display("Lookup outcomes: next %0d, end of chain %0d, bad entry %0d, bad sector %0d",
               status_tally[ST_NEXT], status_tally[ST_END], status_tally[ST_BADENTRY],
               status_tally[ST_BADSECTOR]);
      if (fail_count == 0 && expected_answers.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

### sim.f
sv/fat12_pkg.sv
sv/fat12_divider.sv
sv/fat12_table_store.sv
sv/fat12_next_sector_lookup.sv
tb/tb_fat12_next_sector_lookup.sv
